// File: sv/abe_pkg.sv
// Package for the audio bandwidth estimator: sizes, register map, reset values,
// sequencer states and the structs passed between the submodules.
// No dependencies; every other file imports it.
package abe_pkg;

    localparam int FFT_LEN     = 2048;
    localparam int MAG_BITS    = 24;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int MAG_IN_W    = 24;
    localparam int BW_W        = 10;
    localparam int MEAN_W      = 18;
    localparam int SUM_W       = 32;
    localparam int CNT_W       = 22;
    localparam int MARGIN_W    = 16;
    localparam int MARGIN_FRAC = 14;
    localparam int MEAN_FRAC   = 8;
    localparam int PROD_W      = MAG_BITS + MARGIN_W;
    localparam int DVD_W       = SUM_W + MEAN_FRAC;
    localparam int DIV_CNT_W   = $clog2(DVD_W);
    localparam int PEAK_END    = (FFT_LEN / 2 < STORE_DEPTH) ? FFT_LEN / 2 : STORE_DEPTH;
    localparam int PEAK_LAST   = PEAK_END - 1;
    localparam int CFG_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [CNT_W-1:0]    COUNT_MAX      = {CNT_W{1'b1}};
    localparam logic [BW_W-1:0]     ZERO_THR_RST   = BW_W'(921);
    localparam logic [BW_W-1:0]     MIN_BW_RST     = BW_W'(346);
    localparam logic [MARGIN_W-1:0] REF_MARGIN_RST = MARGIN_W'(51811);
    localparam logic [MARGIN_W-1:0] TST_MARGIN_RST = MARGIN_W'(29135);

    typedef enum logic [1:0] {
        REG_ZERO_THR,
        REG_MIN_BW,
        REG_REF_MARGIN,
        REG_TEST_MARGIN
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PEAK,
        ST_THRESH,
        ST_REF,
        ST_TEST,
        ST_ACC,
        ST_DREF_GO,
        ST_DREF_WAIT,
        ST_DTEST_GO,
        ST_DTEST_WAIT,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic [BW_W-1:0]     zero_thr;
        logic [BW_W-1:0]     min_bw;
        logic [MARGIN_W-1:0] ref_margin;
        logic [MARGIN_W-1:0] test_margin;
    } cfg_t;

    typedef struct packed {
        logic                en;
        logic [ADDR_W-1:0]   addr;
        logic [MAG_BITS-1:0] test_mag;
        logic [MAG_BITS-1:0] ref_mag;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } div_req_t;

endpackage

// File: sv/abe_ifs.sv
// Channel interfaces of the bandwidth estimator: spectral bin input and result output.
// Depends on abe_pkg for field widths.
interface abe_bin_if import abe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MAG_IN_W-1:0] test_mag;
    logic [MAG_IN_W-1:0] ref_mag;
    logic                last_bin;

    modport source (output valid, test_mag, ref_mag, last_bin, input ready);
    modport sink   (input valid, test_mag, ref_mag, last_bin, output ready);
endinterface

interface abe_res_if import abe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BW_W-1:0]   bw_ref;
    logic [BW_W-1:0]   bw_test;
    logic [MEAN_W-1:0] mean_bw_ref_q8;
    logic [MEAN_W-1:0] mean_bw_test_q8;

    modport source (output valid, bw_ref, bw_test, mean_bw_ref_q8, mean_bw_test_q8,
                    input ready);
    modport sink   (input valid, bw_ref, bw_test, mean_bw_ref_q8, mean_bw_test_q8,
                    output ready);
endinterface

// File: sv/abe_cfg.sv
// APB register file for the bandwidth estimator configuration.
// Depends on abe_pkg (register map, reset values, cfg_t).
module abe_cfg import abe_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ZERO_THR:    cfg_next.zero_thr    = pwdata[BW_W-1:0];
                REG_MIN_BW:      cfg_next.min_bw      = pwdata[BW_W-1:0];
                REG_REF_MARGIN:  cfg_next.ref_margin  = pwdata[MARGIN_W-1:0];
                REG_TEST_MARGIN: cfg_next.test_margin = pwdata[MARGIN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ZERO_THR:    prdata = APB_DATA_W'(cfg_reg.zero_thr);
            REG_MIN_BW:      prdata = APB_DATA_W'(cfg_reg.min_bw);
            REG_REF_MARGIN:  prdata = APB_DATA_W'(cfg_reg.ref_margin);
            REG_TEST_MARGIN: prdata = APB_DATA_W'(cfg_reg.test_margin);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_thr    <= ZERO_THR_RST;
            cfg_reg.min_bw      <= MIN_BW_RST;
            cfg_reg.ref_margin  <= REF_MARGIN_RST;
            cfg_reg.test_margin <= TST_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/abe_store.sv
// Spectral bin store: one synchronous memory holding test and reference
// magnitudes side by side, one write and one registered read port.
// Depends on abe_pkg (depth, widths, port structs).
module abe_store import abe_pkg::*; (
    input  logic                clk,
    input  store_wr_t           wr,
    input  store_rd_t           rd,
    output logic [MAG_BITS-1:0] rd_test,
    output logic [MAG_BITS-1:0] rd_ref
);

    logic [2*MAG_BITS-1:0] store_mem [STORE_DEPTH];
    logic [2*MAG_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= {wr.test_mag, wr.ref_mag};
        end
        if (rd.en)
        begin
            rd_data_reg <= store_mem[rd.addr];
        end
    end

    assign rd_test = rd_data_reg[2*MAG_BITS-1:MAG_BITS];
    assign rd_ref  = rd_data_reg[MAG_BITS-1:0];

endmodule

// File: sv/abe_div.sv
// Radix-2 restoring divider for the running means: (sum << 8) / count,
// one quotient bit per cycle; a zero count gives zero at once.
// Depends on abe_pkg (div_req_t, widths).
module abe_div import abe_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              busy,
    output logic              done,
    output logic [MEAN_W-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [MEAN_W-1:0]    q_reg, q_next;
    logic [CNT_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (busy_reg)
        begin
            rem_next = ge ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
            // only the low quotient bits survive the shift; the mean never needs more
            q_next   = {q_reg[MEAN_W-2:0], ge};
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            if (req.cnt == '0)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = DIV_CNT_W'(DVD_W - 1);
                dvd_next  = {req.sum, {MEAN_FRAC{1'b0}}};
                dvs_next  = req.cnt;
                rem_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: sv/abe_seq.sv
// Frame sequencer: loads bins into the store, then runs the peak scan, the
// downward reference and test scans, the accumulators and the mean divisions.
// Depends on abe_pkg, abe_ifs; drives abe_store and abe_div.
module abe_seq import abe_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    abe_bin_if.sink             bin_ch,
    abe_res_if.source           result_ch,
    input  cfg_t                cfg,
    output store_wr_t           st_wr,
    output store_rd_t           st_rd,
    input  logic [MAG_BITS-1:0] rd_test,
    input  logic [MAG_BITS-1:0] rd_ref,
    output div_req_t            div_req,
    input  logic                div_done,
    input  logic [MEAN_W-1:0]   div_quot
);

    seq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    bin_idx_reg, bin_idx_next;
    logic [ADDR_W-1:0]   iss_addr_reg, iss_addr_next;
    logic                iss_on_reg, iss_on_next;
    logic                dv_reg, dv_next;
    logic [ADDR_W-1:0]   daddr_reg, daddr_next;
    logic                dlast_reg, dlast_next;
    logic                first_reg, first_next;
    logic [MAG_BITS-1:0] peak_reg, peak_next;
    logic [PROD_W-1:0]   thr_ref_reg, thr_ref_next;
    logic [PROD_W-1:0]   thr_test_reg, thr_test_next;
    logic [BW_W-1:0]     bw_ref_reg, bw_ref_next;
    logic [BW_W-1:0]     bw_test_reg, bw_test_next;
    logic [SUM_W-1:0]    ref_sum_reg, ref_sum_next;
    logic [CNT_W-1:0]    ref_cnt_reg, ref_cnt_next;
    logic [SUM_W-1:0]    test_sum_reg, test_sum_next;
    logic [CNT_W-1:0]    test_cnt_reg, test_cnt_next;
    logic [MEAN_W-1:0]   mean_ref_reg, mean_ref_next;
    logic [MEAN_W-1:0]   mean_test_reg, mean_test_next;
    logic                out_vld_reg, out_vld_next;
    logic [BW_W-1:0]     o_bw_ref_reg, o_bw_ref_next;
    logic [BW_W-1:0]     o_bw_test_reg, o_bw_test_next;
    logic [MEAN_W-1:0]   o_mref_reg, o_mref_next;
    logic [MEAN_W-1:0]   o_mtest_reg, o_mtest_next;

    logic              bin_acc;
    logic [ADDR_W-1:0] peak_stop;
    logic              ref_hit, test_hit;
    logic              ref_done, test_done, peak_done;
    logic [BW_W-1:0]   bw_ref_new;
    logic              out_free;

    assign bin_acc   = bin_ch.valid && bin_ch.ready;
    // peak region runs to the end of the half spectrum, but always holds the zero threshold bin
    assign peak_stop = (ADDR_W'(cfg.zero_thr) > ADDR_W'(PEAK_LAST)) ?
                       ADDR_W'(cfg.zero_thr) : ADDR_W'(PEAK_LAST);
    // mag * 2^14 >= peak * margin
    assign ref_hit   = dv_reg && (PROD_W'({rd_ref, {MARGIN_FRAC{1'b0}}}) >= thr_ref_reg);
    assign test_hit  = dv_reg && (PROD_W'({rd_test, {MARGIN_FRAC{1'b0}}}) >= thr_test_reg);
    assign ref_done  = dv_reg && (ref_hit || dlast_reg);
    assign test_done = dv_reg && (test_hit || dlast_reg);
    assign peak_done = dv_reg && dlast_reg;
    assign bw_ref_new = ref_hit ? BW_W'(daddr_reg + ADDR_W'(1)) : '0;
    assign out_free  = !out_vld_reg || result_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (bin_acc && bin_ch.last_bin)
                begin
                    state_next = ST_PEAK;
                end
            ST_PEAK:
                if (peak_done)
                begin
                    state_next = ST_THRESH;
                end
            ST_THRESH:
                state_next = (cfg.zero_thr == '0) ? ST_ACC : ST_REF;
            ST_REF:
                if (ref_done)
                begin
                    state_next = (bw_ref_new == '0) ? ST_ACC : ST_TEST;
                end
            ST_TEST:
                if (test_done)
                begin
                    state_next = ST_ACC;
                end
            ST_ACC:
                state_next = ST_DREF_GO;
            ST_DREF_GO:
                state_next = ST_DREF_WAIT;
            ST_DREF_WAIT:
                if (div_done)
                begin
                    state_next = ST_DTEST_GO;
                end
            ST_DTEST_GO:
                state_next = ST_DTEST_WAIT;
            ST_DTEST_WAIT:
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            ST_OUT:
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        bin_idx_next   = bin_idx_reg;
        iss_addr_next  = iss_addr_reg;
        iss_on_next    = iss_on_reg;
        dv_next        = 1'b0;
        daddr_next     = daddr_reg;
        dlast_next     = dlast_reg;
        first_next     = first_reg;
        peak_next      = peak_reg;
        thr_ref_next   = thr_ref_reg;
        thr_test_next  = thr_test_reg;
        bw_ref_next    = bw_ref_reg;
        bw_test_next   = bw_test_reg;
        ref_sum_next   = ref_sum_reg;
        ref_cnt_next   = ref_cnt_reg;
        test_sum_next  = test_sum_reg;
        test_cnt_next  = test_cnt_reg;
        mean_ref_next  = mean_ref_reg;
        mean_test_next = mean_test_reg;
        out_vld_next   = out_vld_reg && !result_ch.ready;
        o_bw_ref_next  = o_bw_ref_reg;
        o_bw_test_next = o_bw_test_reg;
        o_mref_next    = o_mref_reg;
        o_mtest_next   = o_mtest_reg;

        bin_ch.ready   = 1'b0;
        st_wr.en       = 1'b0;
        st_wr.addr     = bin_idx_reg[ADDR_W-1:0];
        st_wr.test_mag = MAG_BITS'(bin_ch.test_mag);
        st_wr.ref_mag  = MAG_BITS'(bin_ch.ref_mag);
        st_rd.en       = 1'b0;
        st_rd.addr     = iss_addr_reg;
        div_req.start  = 1'b0;
        div_req.sum    = ref_sum_reg;
        div_req.cnt    = ref_cnt_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                bin_ch.ready = 1'b1;
                if (bin_acc)
                begin
                    // bins past the store depth are dropped, the index sticks
                    st_wr.en = !bin_idx_reg[ADDR_W];
                    if (!bin_idx_reg[ADDR_W])
                    begin
                        bin_idx_next = bin_idx_reg + IDX_W'(1);
                    end
                    if (bin_ch.last_bin)
                    begin
                        bin_idx_next  = '0;
                        iss_addr_next = ADDR_W'(cfg.zero_thr);
                        iss_on_next   = 1'b1;
                        first_next    = 1'b1;
                    end
                end
            end
            ST_PEAK:
            begin
                if (iss_on_reg)
                begin
                    st_rd.en      = 1'b1;
                    dv_next       = 1'b1;
                    daddr_next    = iss_addr_reg;
                    dlast_next    = (iss_addr_reg == peak_stop);
                    iss_addr_next = iss_addr_reg + ADDR_W'(1);
                    iss_on_next   = (iss_addr_reg != peak_stop);
                end
                if (dv_reg)
                begin
                    first_next = 1'b0;
                    if (first_reg || (rd_test > peak_reg))
                    begin
                        peak_next = rd_test;
                    end
                end
            end
            ST_THRESH:
            begin
                thr_ref_next  = PROD_W'(peak_reg) * PROD_W'(cfg.ref_margin);
                thr_test_next = PROD_W'(peak_reg) * PROD_W'(cfg.test_margin);
                bw_ref_next   = '0;
                bw_test_next  = '0;
                iss_addr_next = ADDR_W'(cfg.zero_thr) - ADDR_W'(1);
                iss_on_next   = 1'b1;
            end
            ST_REF:
            begin
                if (ref_done)
                begin
                    // hand over to the test scan below the reference bandwidth
                    bw_ref_next   = bw_ref_new;
                    iss_addr_next = ADDR_W'(bw_ref_new) - ADDR_W'(1);
                    iss_on_next   = 1'b1;
                end
                else if (iss_on_reg)
                begin
                    st_rd.en      = 1'b1;
                    dv_next       = 1'b1;
                    daddr_next    = iss_addr_reg;
                    dlast_next    = (iss_addr_reg == '0);
                    iss_addr_next = iss_addr_reg - ADDR_W'(1);
                    iss_on_next   = (iss_addr_reg != '0);
                end
            end
            ST_TEST:
            begin
                if (test_done)
                begin
                    bw_test_next = test_hit ? BW_W'(daddr_reg + ADDR_W'(1)) : '0;
                end
                else if (iss_on_reg)
                begin
                    st_rd.en      = 1'b1;
                    dv_next       = 1'b1;
                    daddr_next    = iss_addr_reg;
                    dlast_next    = (iss_addr_reg == '0);
                    iss_addr_next = iss_addr_reg - ADDR_W'(1);
                    iss_on_next   = (iss_addr_reg != '0);
                end
            end
            ST_ACC:
            begin
                if ((bw_ref_reg > cfg.min_bw) && (ref_cnt_reg != COUNT_MAX))
                begin
                    ref_sum_next = ref_sum_reg + SUM_W'(bw_ref_reg);
                    ref_cnt_next = ref_cnt_reg + CNT_W'(1);
                end
                if ((bw_test_reg > cfg.min_bw) && (test_cnt_reg != COUNT_MAX))
                begin
                    test_sum_next = test_sum_reg + SUM_W'(bw_test_reg);
                    test_cnt_next = test_cnt_reg + CNT_W'(1);
                end
            end
            ST_DREF_GO:
            begin
                div_req.start = 1'b1;
            end
            ST_DREF_WAIT:
            begin
                if (div_done)
                begin
                    mean_ref_next = div_quot;
                end
            end
            ST_DTEST_GO:
            begin
                div_req.start = 1'b1;
                div_req.sum   = test_sum_reg;
                div_req.cnt   = test_cnt_reg;
            end
            ST_DTEST_WAIT:
            begin
                if (div_done)
                begin
                    mean_test_next = div_quot;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    o_bw_ref_next  = bw_ref_reg;
                    o_bw_test_next = bw_test_reg;
                    o_mref_next    = mean_ref_reg;
                    o_mtest_next   = mean_test_reg;
                end
            end
            default:
            begin
                bin_ch.ready = 1'b0;
            end
        endcase
    end

    assign result_ch.valid           = out_vld_reg;
    assign result_ch.bw_ref          = o_bw_ref_reg;
    assign result_ch.bw_test         = o_bw_test_reg;
    assign result_ch.mean_bw_ref_q8  = o_mref_reg;
    assign result_ch.mean_bw_test_q8 = o_mtest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            bin_idx_reg  <= '0;
            iss_on_reg   <= 1'b0;
            dv_reg       <= 1'b0;
            first_reg    <= 1'b0;
            peak_reg     <= '0;
            ref_sum_reg  <= '0;
            ref_cnt_reg  <= '0;
            test_sum_reg <= '0;
            test_cnt_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bin_idx_reg  <= bin_idx_next;
            iss_on_reg   <= iss_on_next;
            dv_reg       <= dv_next;
            first_reg    <= first_next;
            peak_reg     <= peak_next;
            ref_sum_reg  <= ref_sum_next;
            ref_cnt_reg  <= ref_cnt_next;
            test_sum_reg <= test_sum_next;
            test_cnt_reg <= test_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_addr_reg  <= iss_addr_next;
        daddr_reg     <= daddr_next;
        dlast_reg     <= dlast_next;
        thr_ref_reg   <= thr_ref_next;
        thr_test_reg  <= thr_test_next;
        bw_ref_reg    <= bw_ref_next;
        bw_test_reg   <= bw_test_next;
        mean_ref_reg  <= mean_ref_next;
        mean_test_reg <= mean_test_next;
        o_bw_ref_reg  <= o_bw_ref_next;
        o_bw_test_reg <= o_bw_test_next;
        o_mref_reg    <= o_mref_next;
        o_mtest_reg   <= o_mtest_next;
    end

endmodule

// File: sv/audio_bandwidth_estimator_core.sv
// Top level of the audio bandwidth estimator: register file, bin store,
// frame sequencer and mean divider. Depends on abe_pkg, abe_ifs and all abe_* modules.
//
//  port      | dir | transaction
//  ----------+-----+---------------------------------------------------------
//  bin_ch    | in  | one spectral bin: test_mag, ref_mag, last_bin
//  result_ch | out | per frame: bw_ref, bw_test, mean_bw_ref_q8, mean_bw_test_q8
//  apb       | in  | configuration writes and reads, pready tied high
//
// Bins load at one per cycle while the sequencer is in its load state. After the last bin
// the single store read port sets the pace: peak scan from zero_threshold_bin upward,
// thresholds, downward reference scan below zero_threshold_bin, downward test scan below
// bw_ref, accumulation, two serial divisions (a zero count gives zero at once) and
// loading the output register. Bins of the next frame are taken while the result
// waits there. Async active-low reset; stores not cleared.
module audio_bandwidth_estimator_core import abe_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    abe_bin_if.sink               bin_ch,
    abe_res_if.source             result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t                cfg;
    store_wr_t           st_wr;
    store_rd_t           st_rd;
    logic [MAG_BITS-1:0] rd_test;
    logic [MAG_BITS-1:0] rd_ref;
    div_req_t            div_req;
    logic                div_busy;
    logic                div_done;
    logic [MEAN_W-1:0]   div_quot;

    abe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    abe_store u_store (
        .clk     (clk),
        .wr      (st_wr),
        .rd      (st_rd),
        .rd_test (rd_test),
        .rd_ref  (rd_ref)
    );

    abe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    abe_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_ch    (bin_ch),
        .result_ch (result_ch),
        .cfg       (cfg),
        .st_wr     (st_wr),
        .st_rd     (st_rd),
        .rd_test   (rd_test),
        .rd_ref    (rd_ref),
        .div_req   (div_req),
        .div_done  (div_done),
        .div_quot  (div_quot)
    );

`ifndef SYNTH
    // loading and scanning never share the store
    a_store_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_wr.en && st_rd.en))
        else $error("store read and write in the same cycle");

    // a frame end stops bin intake for the scans
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (bin_ch.valid && bin_ch.ready && bin_ch.last_bin) |=> !bin_ch.ready)
        else $error("bin accepted right after last bin");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for audio_bandwidth_estimator_core: streams spectral frames,
// predicts per-frame bandwidths and running means, checks every result transaction.
// Depends on abe_pkg, abe_ifs and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import abe_pkg::*;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int TIMEOUT_NS     = 20_000_000;
    localparam int DRAIN_LIMIT    = 100_000;
    localparam int PHASE_SETTLE   = 16;
    localparam int FINAL_SETTLE   = 2500;
    localparam int HOLDOFF_CYCLES = 3000;
    localparam int LONG_FRAME     = STORE_DEPTH + 6;
    localparam int RANDOM_BINS    = 700;
    localparam int RANDOM_FRAMES  = 48;
    localparam int PHASE_BINS     = 90;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {MAG_ZERO, MAG_QUIET, MAG_MID, MAG_LOUD, MAG_FULL} mag_level_t;
    typedef enum int {RX_OPEN, RX_RANDOM, RX_EVERY_FOURTH, RX_MOSTLY_OPEN} rx_mode_t;

    typedef struct packed {
        logic [BW_W-1:0]   bw_ref;
        logic [BW_W-1:0]   bw_test;
        logic [MEAN_W-1:0] mean_ref_q8;
        logic [MEAN_W-1:0] mean_test_q8;
    } frame_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    abe_bin_if bin_ch ();
    abe_res_if result_ch ();

    audio_bandwidth_estimator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_ch    (bin_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // shadow of the register file
    logic [BW_W-1:0]     zero_thr_cfg    = ZERO_THR_RST;
    logic [BW_W-1:0]     min_bw_cfg      = MIN_BW_RST;
    logic [MARGIN_W-1:0] ref_margin_cfg  = REF_MARGIN_RST;
    logic [MARGIN_W-1:0] test_margin_cfg = TST_MARGIN_RST;

    // mirror of the spectral stores and accumulators
    logic [MAG_BITS-1:0] test_mem [STORE_DEPTH];
    logic [MAG_BITS-1:0] ref_mem  [STORE_DEPTH];
    int                  fill_index    = 0;
    logic [SUM_W-1:0]    ref_bw_total  = '0;
    logic [CNT_W-1:0]    ref_bw_frames = '0;
    logic [SUM_W-1:0]    test_bw_total = '0;
    logic [CNT_W-1:0]    test_bw_frames = '0;

    frame_result_t expected_frames [$];

    int unsigned error_count      = 0;
    int unsigned frames_checked   = 0;
    int unsigned frames_sent      = 0;
    int unsigned bins_sent        = 0;
    int unsigned settings_applied = 0;
    int unsigned burst_left       = 0;
    int unsigned holdoff_left     = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d frame results outstanding", expected_frames.size());
        $display("Verification failed");
        $finish;
    end

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] got,
                                          input logic [31:0] want);
        if (got !== want)
        begin
            note_failure($sformatf("frame %0d %s: expected %0d, got %0d",
                                   frames_checked, name, want, got));
        end
    endfunction

    function automatic bit clears_margin(input logic [MAG_BITS-1:0] mag,
                                         input logic [MAG_BITS-1:0] peak,
                                         input logic [MARGIN_W-1:0] margin);
        return (64'(mag) << MARGIN_FRAC) >= 64'(peak) * 64'(margin);
    endfunction

    function automatic void tally(input logic [BW_W-1:0] bw, inout logic [SUM_W-1:0] sum,
                                  inout logic [CNT_W-1:0] count);
        if (bw > min_bw_cfg && count < COUNT_MAX)
        begin
            sum   = sum + SUM_W'(bw);
            count = count + 1'b1;
        end
    endfunction

    function automatic logic [MEAN_W-1:0] running_mean_q8(input logic [SUM_W-1:0] sum,
                                                          input logic [CNT_W-1:0] count);
        logic [63:0] scaled;
        if (count == '0)
        begin
            return '0;
        end
        scaled = 64'(sum) << MEAN_FRAC;
        return MEAN_W'(scaled / 64'(count));
    endfunction

    // Stores one bin; on the frame's last bin works out the bandwidths and means.
    function automatic void estimate_bandwidth(input logic [MAG_IN_W-1:0] tmag,
                                               input logic [MAG_IN_W-1:0] rmag,
                                               input logic last);
        logic [MAG_BITS-1:0] peak;
        logic [BW_W-1:0]     bw_r;
        logic [BW_W-1:0]     bw_t;
        int                  k;
        frame_result_t       r;
        if (fill_index < STORE_DEPTH)
        begin
            test_mem[fill_index] = MAG_BITS'(tmag);
            ref_mem[fill_index]  = MAG_BITS'(rmag);
            fill_index++;
        end
        if (!last)
        begin
            return;
        end
        fill_index = 0;

        peak = test_mem[zero_thr_cfg];
        for (k = zero_thr_cfg; k < PEAK_END; k++)
        begin
            if (test_mem[k] > peak)
            begin
                peak = test_mem[k];
            end
        end
        bw_r = '0;
        for (k = zero_thr_cfg; k > 0; k--)
        begin
            if (clears_margin(ref_mem[k-1], peak, ref_margin_cfg))
            begin
                bw_r = BW_W'(k);
                break;
            end
        end
        bw_t = '0;
        for (k = bw_r; k > 0; k--)
        begin
            if (clears_margin(test_mem[k-1], peak, test_margin_cfg))
            begin
                bw_t = BW_W'(k);
                break;
            end
        end
        tally(bw_r, ref_bw_total, ref_bw_frames);
        tally(bw_t, test_bw_total, test_bw_frames);

        r.bw_ref       = bw_r;
        r.bw_test      = bw_t;
        r.mean_ref_q8  = running_mean_q8(ref_bw_total, ref_bw_frames);
        r.mean_test_q8 = running_mean_q8(test_bw_total, test_bw_frames);
        expected_frames.push_back(r);
    endfunction

    function automatic logic [MAG_IN_W-1:0] rand_mag(input mag_level_t level);
        case (level)
            MAG_ZERO:  return '0;
            MAG_QUIET: return MAG_IN_W'($urandom_range(0, 255));
            MAG_MID:   return MAG_IN_W'($urandom_range(0, 65535));
            MAG_LOUD:  return MAG_IN_W'($urandom);
            default:   return '1;
        endcase
    endfunction

    function automatic mag_level_t pick_level(input mag_level_t lo, input mag_level_t hi);
        return mag_level_t'($urandom_range(lo, hi));
    endfunction

    function automatic logic [APB_DATA_W-1:0] cfg_value(input reg_idx_t idx);
        case (idx)
            REG_ZERO_THR:    return APB_DATA_W'(zero_thr_cfg);
            REG_MIN_BW:      return APB_DATA_W'(min_bw_cfg);
            REG_REF_MARGIN:  return APB_DATA_W'(ref_margin_cfg);
            REG_TEST_MARGIN: return APB_DATA_W'(test_margin_cfg);
            default:         return '0;
        endcase
    endfunction

    // Sender: bursts of random length separated by random gaps.
    task automatic send_bin(input logic [MAG_IN_W-1:0] tmag, input logic [MAG_IN_W-1:0] rmag,
                            input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                bin_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        bin_ch.valid    <= 1'b1;
        bin_ch.test_mag <= tmag;
        bin_ch.ref_mag  <= rmag;
        bin_ch.last_bin <= last;
        do @(posedge clk); while (!bin_ch.ready);
        estimate_bandwidth(tmag, rmag, last);
        burst_left--;
        bins_sent++;
        if (last)
        begin
            frames_sent++;
        end
    endtask

    task automatic send_loud_frame(input int unsigned len);
        int unsigned i;
        for (i = 0; i < len; i++)
        begin
            send_bin(rand_mag(pick_level(MAG_LOUD, MAG_FULL)),
                     rand_mag(pick_level(MAG_LOUD, MAG_FULL)), i == len - 1);
        end
    endtask

    // Shaped frames: strong below a cutoff (loud reference, mid or louder test), quiet above; otherwise random levels.
    task automatic send_frame(input bit shaped);
        int unsigned len;
        int unsigned ref_cut;
        int unsigned test_cut;
        int unsigned i;
        logic [MAG_IN_W-1:0] tmag;
        logic [MAG_IN_W-1:0] rmag;
        if ($urandom_range(0, 31) == 0)
        begin
            len = $urandom_range(64, 256);
        end
        else if (shaped && zero_thr_cfg < 24)
        begin
            len = zero_thr_cfg + $urandom_range(1, 4);
        end
        else
        begin
            len = $urandom_range(1, 12);
        end
        ref_cut  = $urandom_range(0, len);
        test_cut = $urandom_range(0, len);
        for (i = 0; i < len; i++)
        begin
            if (shaped)
            begin
                rmag = rand_mag(i < ref_cut ? pick_level(MAG_LOUD, MAG_FULL)
                                            : pick_level(MAG_ZERO, MAG_QUIET));
                tmag = rand_mag(i < test_cut ? pick_level(MAG_MID, MAG_FULL)
                                             : pick_level(MAG_ZERO, MAG_QUIET));
            end
            else
            begin
                rmag = rand_mag(pick_level(MAG_ZERO, MAG_FULL));
                tmag = rand_mag(pick_level(MAG_ZERO, MAG_FULL));
            end
            send_bin(tmag, rmag, i == len - 1);
        end
    endtask

    // Waits until every expected frame result has arrived (or the drain limit runs out), then lets the block settle.
    task automatic wait_idle(input int unsigned settle);
        int unsigned waited;
        waited = 0;
        bin_ch.valid <= 1'b0;
        while (expected_frames.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic check_reg(input reg_idx_t idx);
        logic [APB_DATA_W-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (data !== cfg_value(idx))
        begin
            note_failure($sformatf("register %s read: expected %0d, got %0d",
                                   idx.name(), cfg_value(idx), data));
        end
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ZERO_THR:    zero_thr_cfg    = value[BW_W-1:0];
            REG_MIN_BW:      min_bw_cfg      = value[BW_W-1:0];
            REG_REF_MARGIN:  ref_margin_cfg  = value[MARGIN_W-1:0];
            REG_TEST_MARGIN: test_margin_cfg = value[MARGIN_W-1:0];
            default:         ;
        endcase
        @(posedge clk);
        check_reg(idx);
    endtask

    task automatic apply_settings(input logic [BW_W-1:0] zt, input logic [BW_W-1:0] min_bw,
                                  input logic [MARGIN_W-1:0] ref_margin,
                                  input logic [MARGIN_W-1:0] test_margin);
        write_reg(REG_ZERO_THR, APB_DATA_W'(zt));
        write_reg(REG_MIN_BW, APB_DATA_W'(min_bw));
        write_reg(REG_REF_MARGIN, APB_DATA_W'(ref_margin));
        write_reg(REG_TEST_MARGIN, APB_DATA_W'(test_margin));
        settings_applied++;
    endtask

    function automatic logic [MARGIN_W-1:0] pick_margin(input logic [MARGIN_W-1:0] nominal);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2, 3:    return nominal;
            default: return MARGIN_W'($urandom);
        endcase
    endfunction

    task automatic apply_random_settings();
        logic [BW_W-1:0] zt;
        logic [BW_W-1:0] min_bw;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: zt = BW_W'($urandom_range(1, 24));
            5, 6:          zt = BW_W'($urandom_range(25, 96));
            7:             zt = BW_W'($urandom_range(97, 1022));
            8:             zt = '1;
            default:       zt = BW_W'(1);
        endcase
        case ($urandom_range(0, 3))
            0:       min_bw = '0;
            1:       min_bw = '1;
            2:       min_bw = BW_W'($urandom_range(0, 32));
            default: min_bw = BW_W'($urandom);
        endcase
        apply_settings(zt, min_bw, pick_margin(REF_MARGIN_RST), pick_margin(TST_MARGIN_RST));
    endtask

    task automatic test_register_defaults();
        reg_idx_t idx;
        idx = idx.first();
        do
        begin
            check_reg(idx);
            idx = idx.next();
        end
        while (idx != idx.first());
    endtask

    // Fills the whole store once (nothing unwritten is ever scanned afterwards) and runs
    // past the store depth. Upper bins stay quiet; the top ones carry zero test magnitude.
    task automatic test_long_frame();
        int unsigned i;
        logic [MAG_IN_W-1:0] tmag;
        logic [MAG_IN_W-1:0] rmag;
        for (i = 0; i < LONG_FRAME; i++)
        begin
            if (i == 0)
            begin
                tmag = '1;
                rmag = '1;
            end
            else if (i == 1)
            begin
                tmag = '0;
                rmag = '0;
            end
            else if (i < 24)
            begin
                tmag = rand_mag(pick_level(MAG_MID, MAG_FULL));
                rmag = rand_mag(pick_level(MAG_LOUD, MAG_FULL));
            end
            else if (i < STORE_DEPTH - 24)
            begin
                tmag = rand_mag(pick_level(MAG_ZERO, MAG_QUIET));
                rmag = rand_mag(pick_level(MAG_ZERO, MAG_QUIET));
            end
            else if (i < STORE_DEPTH)
            begin
                tmag = '0;
                rmag = rand_mag(MAG_QUIET);
            end
            else
            begin
                // beyond the store: dropped by the block
                tmag = rand_mag(MAG_LOUD);
                rmag = rand_mag(MAG_LOUD);
            end
            send_bin(tmag, rmag, i == LONG_FRAME - 1);
        end
        wait_idle(PHASE_SETTLE);
    endtask

    task automatic test_threshold_extremes();
        // top bin as the whole peak region, whose peak is zero: every bin qualifies
        apply_settings('1, '0, REF_MARGIN_RST, TST_MARGIN_RST);
        send_loud_frame(3);
        wait_idle(PHASE_SETTLE);
        // empty reference scan, nothing can be counted
        apply_settings('0, '1, REF_MARGIN_RST, TST_MARGIN_RST);
        send_loud_frame(2);
        wait_idle(PHASE_SETTLE);
        apply_settings(BW_W'(1), '0, REF_MARGIN_RST, TST_MARGIN_RST);
        send_loud_frame(2);
        wait_idle(PHASE_SETTLE);
    endtask

    task automatic test_margin_extremes();
        apply_settings(BW_W'(32), '0, '0, '0);
        send_loud_frame(4);
        wait_idle(PHASE_SETTLE);
        apply_settings(BW_W'(32), BW_W'(16), '1, '1);
        send_loud_frame(4);
        wait_idle(PHASE_SETTLE);
    endtask

    // Result side held off while frames keep coming, so the input stalls.
    task automatic test_result_backpressure();
        int unsigned n;
        apply_settings(BW_W'(8), BW_W'(4), REF_MARGIN_RST, TST_MARGIN_RST);
        holdoff_left = HOLDOFF_CYCLES;
        for (n = 0; n < 6; n++)
        begin
            send_loud_frame(2);
        end
        wait_idle(PHASE_SETTLE);
    endtask

    task automatic test_random_frames();
        int unsigned start_bins;
        int unsigned start_frames;
        int unsigned phase_start;
        start_bins   = bins_sent;
        start_frames = frames_sent;
        while (bins_sent - start_bins < RANDOM_BINS || frames_sent - start_frames < RANDOM_FRAMES)
        begin
            apply_random_settings();
            phase_start = bins_sent;
            while (bins_sent - phase_start < PHASE_BINS)
            begin
                send_frame($urandom_range(0, 9) < 7);
            end
            wait_idle(PHASE_SETTLE);
        end
    endtask

    // Receiver: stalls on its own changing pattern and checks each result transaction.
    initial
    begin : result_monitor
        frame_result_t want;
        rx_mode_t      rx_mode;
        int unsigned   mode_left;
        int unsigned   rx_tick;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        rx_tick   = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    note_failure("result transaction with no frame pending");
                end
                else
                begin
                    want = expected_frames.pop_front();
                    compare_field("bw_ref", result_ch.bw_ref, want.bw_ref);
                    compare_field("bw_test", result_ch.bw_test, want.bw_test);
                    compare_field("mean_bw_ref_q8", result_ch.mean_bw_ref_q8,
                                  want.mean_ref_q8);
                    compare_field("mean_bw_test_q8", result_ch.mean_bw_test_q8,
                                  want.mean_test_q8);
                end
                frames_checked++;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(RX_OPEN, RX_MOSTLY_OPEN));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            rx_tick++;
            if (holdoff_left != 0)
            begin
                result_ch.ready <= 1'b0;
                holdoff_left--;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:         result_ch.ready <= 1'b1;
                    RX_RANDOM:       result_ch.ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: result_ch.ready <= (rx_tick % 4 == 0);
                    default:         result_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        bin_ch.valid    <= 1'b0;
        bin_ch.test_mag <= '0;
        bin_ch.ref_mag  <= '0;
        bin_ch.last_bin <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_long_frame();
        test_threshold_extremes();
        test_margin_extremes();
        test_result_backpressure();
        test_random_frames();

        wait_idle(FINAL_SETTLE);
        if (expected_frames.size() != 0)
        begin
            note_failure($sformatf("%0d frame results never arrived", expected_frames.size()));
        end
        $display("Checked %0d frame results from %0d bins under %0d register settings.",
                 frames_checked, bins_sent, settings_applied);
        $display("Mix: store overflow frame, threshold/margin extremes, %0d-cycle output stall.",
                 HOLDOFF_CYCLES);
        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d failures", error_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/abe_pkg.sv
sv/abe_ifs.sv
sv/abe_cfg.sv
sv/abe_store.sv
sv/abe_div.sv
sv/abe_seq.sv
sv/audio_bandwidth_estimator_core.sv
test/tb_top.sv
